// ===== rtl/bounded_array_set_macros.svh =====
// Assertion macros used by the bounded array set sequencer (bas_ctrl).
`ifndef BOUNDED_ARRAY_SET_MACROS_SVH
`define BOUNDED_ARRAY_SET_MACROS_SVH

// Condition holds at every rising clock edge outside reset.
`define BAS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bas_pkg.sv =====
// Shared types and constants of the bounded array set.
package bas_pkg;

   localparam int BAS_MAX_ENTRIES = 64;
   localparam int BAS_VALUE_WIDTH = 32;

   localparam int ITEM_W      = 32;
   localparam int CMD_W       = 2;
   localparam int CAP_W       = 7;
   localparam int COUNT_OUT_W = 7;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Register index as decoded from the word part of the address.
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_COMMIT
   } bas_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } bas_mem_ctl_type;

endpackage

// ===== rtl/bas_store.sv =====
// Entry memory: one write port, one read port with registered read data.
module bas_store
   import bas_pkg::*;
#(
   parameter int DEPTH  = BAS_MAX_ENTRIES,
   parameter int DATA_W = BAS_VALUE_WIDTH,
   parameter int ADDR_W = $clog2(BAS_MAX_ENTRIES)
) (
   input  logic                  clock,
   input  bas_mem_ctl_type       mem_ctl,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_W-1:0]     wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_W-1:0]     rd_data
);

   logic [DATA_W-1:0] entry_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bas_csr.sv =====
// Configuration register block with the capacity limit register.
module bas_csr
   import bas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CAP_W-1:0]      capacity_limit
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_hit) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CAPACITY) begin
         csr_prdata = {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff};
      end
   end

   assign capacity_limit = capacity_ff;

endmodule

// ===== rtl/bas_ctrl.sv =====
// Command sequencer: linear search, erase shift, append and result register.
`include "bounded_array_set_macros.svh"

module bas_ctrl
   import bas_pkg::*;
#(
   parameter int MAX_ENTRIES = BAS_MAX_ENTRIES,
   parameter int VALUE_WIDTH = BAS_VALUE_WIDTH,
   parameter int IDX_W       = $clog2(BAS_MAX_ENTRIES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [ITEM_W-1:0]      req_item_value,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_was_present,
   output logic                   rsp_rejected_full,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input  logic [CAP_W-1:0]       capacity_limit,
   output bas_mem_ctl_type        mem_ctl,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [VALUE_WIDTH-1:0] wr_data,
   output logic [IDX_W-1:0]       rd_addr,
   input  logic [VALUE_WIDTH-1:0] rd_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int LIM_W = CNT_W + CAP_W;

   bas_state_type state_ff, state_in;

   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   present_ff, present_in;
   logic [CMD_W-1:0]       cmd_ff;
   logic [VALUE_WIDTH-1:0] key_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic                   rsp_reject_ff, rsp_reject_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   stall;
   logic                   hit;
   logic                   last;
   logic [CNT_W-1:0]       idx_next;
   logic [CNT_W-1:0]       rd_addr_full;
   logic [CNT_W-1:0]       wr_addr_full;
   logic [2*ITEM_W-1:0]    item_ext;
   logic [LIM_W-1:0]       cap_ext;
   logic [LIM_W-1:0]       count_ext;
   logic [LIM_W-1:0]       max_ext;
   logic [LIM_W-1:0]       limit_ext;
   logic                   room;
   logic                   do_append;
   logic                   do_remove;
   logic                   is_insert;
   logic [CNT_W+COUNT_OUT_W-1:0] count_out_ext;

   assign accept   = req_tvalid && req_tready;
   assign stall    = rsp_valid_ff && !rsp_tready;
   assign hit      = (rd_data == key_ff);
   assign idx_next = idx_ff + 1'b1;
   assign last     = (idx_next == count_ff);
   assign item_ext = {{ITEM_W{1'b0}}, req_item_value};

   // Effective limit is the smaller of the register and the depth.
   assign cap_ext   = {{CNT_W{1'b0}}, capacity_limit};
   assign count_ext = {{CAP_W{1'b0}}, count_ff};
   assign max_ext   = LIM_W'(MAX_ENTRIES);
   assign limit_ext = (cap_ext < max_ext) ? cap_ext : max_ext;
   assign room      = (count_ext < limit_ext);

   assign is_insert = (cmd_ff == CMD_INSERT);
   assign do_append = is_insert && !present_ff && room;
   assign do_remove = (cmd_ff == CMD_ERASE) && present_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (count_ff == '0) ? ST_COMMIT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = (cmd_ff == CMD_ERASE) ? ST_SHIFT : ST_COMMIT;
            end else if (last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_SHIFT: begin
            if (idx_ff == count_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      idx_in         = idx_ff;
      count_in       = count_ff;
      present_in     = present_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_present_in = rsp_present_ff;
      rsp_reject_in  = rsp_reject_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr_full   = idx_next;
      wr_addr_full   = '0;
      wr_data        = rd_data;
      mem_ctl.wr_en  = 1'b0;
      mem_ctl.rd_en  = 1'b0;
      count_out_ext  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            rd_addr_full = '0;
            mem_ctl.rd_en = (count_ff != '0);
            if (req_tvalid) begin
               idx_in     = '0;
               present_in = 1'b0;
            end
         end
         ST_SEARCH: begin
            // Prefetch the next entry while comparing the current one.
            mem_ctl.rd_en = (idx_next < count_ff);
            idx_in        = idx_next;
            if (hit) begin
               present_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            // Move entry idx down to idx-1 and prefetch idx+1.
            mem_ctl.rd_en = (idx_next < count_ff);
            if (idx_ff != count_ff) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr_full  = idx_ff - 1'b1;
               idx_in        = idx_next;
            end
         end
         ST_COMMIT: begin
            wr_data      = key_ff;
            wr_addr_full = count_ff;
            if (!stall) begin
               mem_ctl.wr_en = do_append;
               if (do_append) begin
                  count_in = count_ff + 1'b1;
               end else if (do_remove) begin
                  count_in = count_ff - 1'b1;
               end
               count_out_ext  = {{COUNT_OUT_W{1'b0}}, count_in};
               rsp_valid_in   = 1'b1;
               rsp_present_in = present_ff;
               rsp_reject_in  = is_insert && !present_ff && !room;
               rsp_count_in   = count_out_ext[COUNT_OUT_W-1:0];
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rd_addr = rd_addr_full[IDX_W-1:0];
   assign wr_addr = wr_addr_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      present_ff     <= present_in;
      rsp_present_ff <= rsp_present_in;
      rsp_reject_ff  <= rsp_reject_in;
      rsp_count_ff   <= rsp_count_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= item_ext[VALUE_WIDTH-1:0];
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_was_present   = rsp_present_ff;
   assign rsp_rejected_full = rsp_reject_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `BAS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES), "count above depth")
   `BAS_ASSERT_IMP(a_search_in_range, clock, reset, state_ff == ST_SEARCH, idx_ff < count_ff, "search index beyond count")
   `BAS_ASSERT_IMP(a_shift_on_erase, clock, reset, state_ff == ST_SHIFT, present_ff && (cmd_ff == CMD_ERASE), "shift without erase hit")
   `BAS_ASSERT_NEXT(a_append_counts, clock, reset, (state_ff == ST_COMMIT) && !stall && do_append, count_ff == CNT_W'($past(count_ff) + 1'b1), "append did not advance count")
   `BAS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE, "accepted transaction left sequencer idle")

endmodule

// ===== rtl/bounded_array_set.sv =====
// Bounded set of distinct values: one command in, one result out per transaction.
// From accept, a linear search reads the used entries in order until a hit or the last one
// (none on an empty set); erase of a present value then shifts the later entries down one
// slot. The next command is taken in the same cycle that the result appears on rsp_tvalid.
// The single-port read of the entry memory, one entry per cycle, sets the rate.
// Reset (synchronous, active high): empty set, capacity limit 64, memory contents kept.
module bounded_array_set
   import bas_pkg::*;
#(
   parameter int MAX_ENTRIES = BAS_MAX_ENTRIES,
   parameter int VALUE_WIDTH = BAS_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ITEM_W-1:0]     req_tdata,   // [31:0] item_value
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] was_present, [1] rejected_full,
                                              // [8:2] entry_count, [15:9] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   logic [CAP_W-1:0]       capacity_limit;
   bas_mem_ctl_type        mem_ctl;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   was_present;
   logic                   rejected_full;
   logic [COUNT_OUT_W-1:0] entry_count;

   bas_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .capacity_limit (capacity_limit)
   );

   bas_store #(
      .DEPTH  (MAX_ENTRIES),
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bas_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_cmd           (req_tuser),
      .req_item_value    (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_was_present   (was_present),
      .rsp_rejected_full (rejected_full),
      .rsp_entry_count   (entry_count),
      .capacity_limit    (capacity_limit),
      .mem_ctl           (mem_ctl),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data)
   );

   assign rsp_tdata = {{(RSP_DATA_W-COUNT_OUT_W-2){1'b0}}, entry_count, rejected_full,
                       was_present};

endmodule
